[rtl/core/lpti_pkg.sv]
// ----------------------------------------------------------------------------
// Pose interpolator package
// Shared widths, constants and payload types of the pose interpolator.
// ----------------------------------------------------------------------------
package lpti_pkg;

    localparam int TIME_W  = 48;
    localparam int VALUE_W = 32;
    localparam int TOL_W   = 20;
    localparam int NUM_VALUES = 10;
    localparam logic [TOL_W-1:0] TOL_RESET = 20'd10000;

    localparam logic KIND_PUSH  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef t_value [NUM_VALUES-1:0] t_values;

    typedef struct packed {
        logic               kind;
        logic [TIME_W-1:0]  time_us;
        t_values            vals;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic [TIME_W-1:0]  pose_time_us;
        t_values            vals;
    } t_out_item;

    // Lane control issued by the sequencer.
    typedef struct packed {
        logic start;
        logic load;
    } t_lane_ctrl;

endpackage

[rtl/core/lpti_if.sv]
// ----------------------------------------------------------------------------
// Pose interpolator stream interfaces
// Valid/ready channels for the input and result items.
// ----------------------------------------------------------------------------
interface lpti_in_if;
    logic               valid;
    logic               ready;
    lpti_pkg::t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lpti_out_if;
    logic                valid;
    logic                ready;
    lpti_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/lpti_divider.sv]
// ----------------------------------------------------------------------------
// Pose interpolator ratio divider
// Restoring divider, one quotient bit per cycle, num <= den.
// ----------------------------------------------------------------------------
module lpti_divider #(
    parameter int RATIO_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lpti_pkg::TIME_W-1:0] i_num,
    input  logic [lpti_pkg::TIME_W-1:0] i_den,
    output logic                        o_done,
    output logic [RATIO_BITS:0]         o_ratio
);
    localparam int CNT_W = $clog2(RATIO_BITS + 1);

    logic [lpti_pkg::TIME_W:0]   r_rem;
    logic [lpti_pkg::TIME_W-1:0] r_den;
    logic [RATIO_BITS:0]         r_q;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [lpti_pkg::TIME_W:0]   n_shift;

    assign n_shift = {r_rem[lpti_pkg::TIME_W-1:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_den  <= i_den;
                r_cnt  <= CNT_W'(RATIO_BITS);
                if (i_num >= i_den) begin
                    r_q   <= (RATIO_BITS+1)'(1);
                    r_rem <= {1'b0, i_num - i_den};
                end else begin
                    r_q   <= '0;
                    r_rem <= {1'b0, i_num};
                end
            end else if (r_busy) begin
                if (n_shift >= {1'b0, r_den}) begin
                    r_rem <= n_shift - {1'b0, r_den};
                    r_q   <= {r_q[RATIO_BITS-1:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_q   <= {r_q[RATIO_BITS-1:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_ratio = r_q;
endmodule

[rtl/core/lpti_lane.sv]
// ----------------------------------------------------------------------------
// Pose interpolator lane
// Interpolates one value: prev + ratio * (later - prev), truncated to zero.
// ----------------------------------------------------------------------------
module lpti_lane #(
    parameter int RATIO_BITS = 16
) (
    input  logic                 i_clk,
    input  lpti_pkg::t_lane_ctrl i_ctrl,
    input  lpti_pkg::t_value     i_prev,
    input  lpti_pkg::t_value     i_later,
    input  logic [RATIO_BITS:0]  i_ratio,
    output lpti_pkg::t_value     o_result
);
    localparam int VW = lpti_pkg::VALUE_W;

    logic [VW:0]              r_mag;
    logic                     r_neg;
    logic signed [VW:0]       r_prev;
    logic [VW+RATIO_BITS:0]   r_prod;
    logic signed [VW:0]       n_diff;
    logic signed [VW+1:0]     n_res;
    logic [VW:0]              n_step;
    logic [VW+RATIO_BITS:0]   n_prod;

    assign n_diff = {i_later[VW-1], i_later} - {i_prev[VW-1], i_prev};
    assign n_prod = r_mag * i_ratio;
    assign n_step = r_prod[VW+RATIO_BITS -: VW+1];
    assign n_res  = r_neg ? {r_prev[VW], r_prev} - {1'b0, n_step}
                          : {r_prev[VW], r_prev} + {1'b0, n_step};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_neg  <= n_diff[VW];
            r_mag  <= n_diff[VW] ? (VW+1)'(-n_diff) : n_diff;
            r_prev <= {i_prev[VW-1], i_prev};
        end
        if (i_ctrl.start) begin
            r_prod <= n_prod;
        end
    end

    assign o_result = n_res[VW-1:0];
endmodule

[rtl/core/local_pose_time_interpolator.sv]
// ----------------------------------------------------------------------------
// Local pose time interpolator
// Timestamped pose queue with linear interpolation at a query stamp.
// ----------------------------------------------------------------------------
// A push item is accepted in the idle state and stores a sample in a circular
// queue of QUEUE_DEPTH entries, so pushes can follow back to back. A query
// item walks the queue head through the sample memory, passing through the
// READ and TEST states for each popped sample; when two neighbors exist it
// then runs the divider in DIV and the lanes in MUL, and the result is set
// valid in OUT.
// Ten interpolation lanes share the ratio and each handles one pose value;
// the merge stage assembles them into the result item. The result sits in an
// output register, and the next item is taken once that register is free.
// A push with the same time as the last push is ignored and a push into a
// full queue is dropped. A lone neighbour is returned only when its distance
// from the stamp is strictly below the tolerance register.
module local_pose_time_interpolator #(
    parameter int QUEUE_DEPTH = 16,
    parameter int RATIO_BITS  = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [lpti_pkg::TOL_W-1:0] i_cfg_wdata,
    lpti_in_if.sink                  i_in,
    lpti_out_if.source               o_out
);
    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = lpti_pkg::TIME_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_TEST = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    // Sample memory: time and values at one address.
    logic [TW-1:0]     r_mem_t [QUEUE_DEPTH];
    lpti_pkg::t_values r_mem_v [QUEUE_DEPTH];
    logic [TW-1:0]     r_rd_t;
    lpti_pkg::t_values r_rd_v;

    logic [2:0]            r_state;
    logic [lpti_pkg::TOL_W-1:0] r_tol;
    logic [IW-1:0]         r_head;
    logic [CW-1:0]         r_count;
    logic [TW-1:0]         r_last_t;
    logic                  r_any;
    logic [TW-1:0]         r_stamp;
    logic                  r_have_prev;
    logic [TW-1:0]         r_prev_t;
    lpti_pkg::t_values     r_prev_v;
    logic                  r_out_valid;
    lpti_pkg::t_out_item   r_out;
    logic                  r_mul_wait;

    logic                  n_accept;
    logic                  n_wr;
    logic [IW-1:0]         n_slot;
    logic [IW:0]           n_sum;
    logic                  n_start_div;
    logic                  n_div_done;
    logic [RATIO_BITS:0]   n_ratio;
    lpti_pkg::t_lane_ctrl  n_lane_ctrl;
    lpti_pkg::t_values     n_lane_res;

    assign i_in.ready = (r_state == ST_IDLE) && !r_out_valid;
    assign n_accept   = i_in.valid && i_in.ready;
    assign n_wr = n_accept && (i_in.payload.kind == lpti_pkg::KIND_PUSH)
               && !(r_any && i_in.payload.time_us == r_last_t)
               && (r_count < CW'(QUEUE_DEPTH));
    assign n_sum  = {1'b0, r_head} + (IW+1)'(r_count);
    assign n_slot = (n_sum >= (IW+1)'(QUEUE_DEPTH))
                  ? IW'(n_sum - (IW+1)'(QUEUE_DEPTH)) : n_sum[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            r_mem_t[n_slot] <= i_in.payload.time_us;
            r_mem_v[n_slot] <= i_in.payload.vals;
        end
        r_rd_t <= r_mem_t[r_head];
        r_rd_v <= r_mem_v[r_head];
    end

    assign n_start_div = (r_state == ST_TEST) && (r_count != '0)
                      && !(r_rd_t < r_stamp) && r_have_prev;
    assign n_lane_ctrl.load  = n_start_div;
    assign n_lane_ctrl.start = n_div_done;

    lpti_divider #(.RATIO_BITS(RATIO_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_start_div),
        .i_num   (r_stamp - r_prev_t),
        .i_den   (r_rd_t - r_prev_t),
        .o_done  (n_div_done),
        .o_ratio (n_ratio)
    );

    // One lane per pose value; each sees the later sample in the read register.
    for (genvar g = 0; g < lpti_pkg::NUM_VALUES; g++) begin : g_lane
        lpti_lane #(.RATIO_BITS(RATIO_BITS)) u_lane (
            .i_clk    (i_clk),
            .i_ctrl   (n_lane_ctrl),
            .i_prev   (r_prev_v[g]),
            .i_later  (r_rd_v[g]),
            .i_ratio  (n_ratio),
            .o_result (n_lane_res[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tol       <= lpti_pkg::TOL_RESET;
            r_head      <= '0;
            r_count     <= '0;
            r_last_t    <= '0;
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
            r_have_prev <= 1'b0;
            r_mul_wait  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (n_accept) begin
                        if (i_in.payload.kind == lpti_pkg::KIND_PUSH) begin
                            if (!(r_any && i_in.payload.time_us == r_last_t)) begin
                                r_last_t <= i_in.payload.time_us;
                                r_any    <= 1'b1;
                                if (n_wr) begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                        end else begin
                            r_stamp     <= i_in.payload.time_us;
                            r_have_prev <= 1'b0;
                            r_state     <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    r_state <= ST_TEST;
                end
                ST_TEST: begin
                    if (r_count != '0 && r_rd_t < r_stamp) begin
                        // Pop the head into the previous neighbour.
                        r_have_prev <= 1'b1;
                        r_prev_t    <= r_rd_t;
                        r_prev_v    <= r_rd_v;
                        r_head      <= (r_head == IW'(QUEUE_DEPTH - 1)) ? '0
                                                                       : r_head + 1'b1;
                        r_count     <= r_count - 1'b1;
                        r_state     <= ST_READ;
                    end else if (n_start_div) begin
                        r_state <= ST_DIV;
                    end else begin
                        if (r_have_prev && (r_stamp - r_prev_t) < TW'(r_tol)) begin
                            r_out.found        <= 1'b1;
                            r_out.pose_time_us <= r_prev_t;
                            r_out.vals         <= r_prev_v;
                        end else if (r_count != '0
                                     && (r_rd_t - r_stamp) < TW'(r_tol)) begin
                            r_out.found        <= 1'b1;
                            r_out.pose_time_us <= r_rd_t;
                            r_out.vals         <= r_rd_v;
                        end else begin
                            r_out.found        <= 1'b0;
                            r_out.pose_time_us <= '0;
                            r_out.vals         <= '0;
                        end
                        r_state <= ST_OUT;
                    end
                end
                ST_DIV: begin
                    if (n_div_done) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    // Lane products land in the cycle after the ratio; merge them.
                    r_out.found        <= 1'b1;
                    r_out.pose_time_us <= r_stamp;
                    r_out.vals         <= n_lane_res;
                    r_state            <= ST_OUT;
                end
                ST_OUT: begin
                    r_out_valid <= 1'b1;
                    r_state     <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            r_mul_wait <= n_div_done;
        end
    end

    assign o_out.valid   = r_out_valid && !r_mul_wait;
    assign o_out.payload = r_out;
endmodule
